@@ hw/rtl/cbm_pkg.sv @@
// Package for the cartridge bank mapper: payload types, kind codes, constants.
// No dependencies.
package cbm_pkg;

	localparam int ImagePages = 256;
	localparam int PageW = 8;
	localparam logic [8:0] OssOff = 9'h100;

	localparam logic [1:0] RegKind  = 2'd0;
	localparam logic [1:0] RegOlder = 2'd1;
	localparam logic [1:0] RegBasic = 2'd2;

	localparam logic [5:0] K_STD_8 = 6'd1, K_STD_16 = 6'd2, K_OSS_16 = 6'd3,
		K_DB_32 = 6'd5, K_WILL_64 = 6'd8, K_EXP_64 = 6'd9, K_DIAMOND_64 = 6'd10,
		K_SDX_64 = 6'd11, K_XEGS_32 = 6'd12, K_XEGS_64 = 6'd13, K_XEGS_128 = 6'd14,
		K_OSS2_16 = 6'd15, K_ATRAX_128 = 6'd17, K_BBSB_40 = 6'd18,
		K_RIGHT_8 = 6'd21, K_WILL_32 = 6'd22, K_XEGS_256 = 6'd23,
		K_XEGS_512 = 6'd24, K_XEGS_1024 = 6'd25, K_MEGA_16 = 6'd26,
		K_MEGA_1024 = 6'd32, K_SWXEGS_32 = 6'd33, K_SWXEGS_64 = 6'd34,
		K_SWXEGS_128 = 6'd35, K_SWXEGS_256 = 6'd36, K_SWXEGS_512 = 6'd37,
		K_SWXEGS_1024 = 6'd38, K_PHOENIX_8 = 6'd39, K_BLIZZARD_16 = 6'd40,
		K_ATMAX_128 = 6'd41, K_ATMAX_1024 = 6'd42, K_SDX_128 = 6'd43;

	typedef struct packed {
		logic       req_type;
		logic [7:0] page_offset;
		logic [7:0] write_value;
	} in_item_t;

	typedef struct packed {
		logic       [7:0] read_value;
		logic             low_window_on;
		logic             high_window_on;
		logic             high_from_basic;
		logic [PageW-1:0] page_at_8000;
		logic [PageW-1:0] page_at_9000;
		logic [PageW-1:0] page_at_a000;
		logic [PageW-1:0] page_at_b000;
	} out_item_t;

	// mapping state
	typedef struct packed {
		logic [8:0] bank;
		logic [7:0] p0, p1, p2, p3;
		logic       lo_en, hi_en, basic;
	} map_t;

	// classified access handed from front to back
	typedef struct packed {
		logic       is_write;
		logic [7:0] addr;
		logic [7:0] data;
	} op_t;

	// page index wrapped to the image size (a power of two)
	function automatic logic [7:0] pg(input logic [8:0] v);
		return v[7:0] & 8'(ImagePages - 1);
	endfunction

endpackage

@@ hw/rtl/cbm_front.sv @@
// Front: accepts items into a two-entry queue.
// Depends on cbm_pkg.
module cbm_front import cbm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	output logic     op_valid,
	input  logic     op_ready,
	output op_t      op
);
	op_t        fifo_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = cnt_q != 2'd2;
	assign op_valid = cnt_q != 2'd0;
	assign op = fifo_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = op_valid && op_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= '{in_data.req_type, in_data.page_offset, in_data.write_value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

@@ hw/rtl/cbm_back.sv @@
// Back: applies the cartridge kind's banking rule and holds the mapping.
// Depends on cbm_pkg.
module cbm_back import cbm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      op_valid,
	output logic      op_ready,
	input  op_t       op,
	input  logic      kind_wr,
	input  logic [5:0] kind,
	input  logic [5:0] kind_new,
	input  logic      older,
	input  logic      basic_wanted,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);
	map_t m_q, nx, st;
	logic out_valid_q;
	out_item_t out_q;

	function automatic map_t hi8(input map_t s, input logic [7:0] k);
		map_t r = s;
		r.p2 = {k[6:0], 1'b0};
		r.p3 = {k[6:0], 1'b1};
		r.hi_en = 1'b1;
		return r;
	endfunction

	function automatic map_t lo8(input map_t s, input logic [7:0] k);
		map_t r = s;
		r.p0 = {k[6:0], 1'b0};
		r.p1 = {k[6:0], 1'b1};
		r.lo_en = 1'b1;
		return r;
	endfunction

	function automatic map_t m16(input map_t s, input logic [7:0] k);
		map_t r = s;
		r.p0 = {k[5:0], 2'd0};
		r.p1 = {k[5:0], 2'd1};
		r.p2 = {k[5:0], 2'd2};
		r.p3 = {k[5:0], 2'd3};
		r.lo_en = 1'b1;
		r.hi_en = 1'b1;
		return r;
	endfunction

	function automatic map_t xegs(input map_t s, input logic [7:0] b, input logic [7:0] last);
		map_t r = s;
		if (b[7]) begin
			r.lo_en = 1'b0;
			r.hi_en = 1'b0;
		end else begin
			r = hi8(lo8(r, {1'b0, b[6:0]}), last);
		end
		r.bank = {1'b0, b};
		return r;
	endfunction

	function automatic map_t oss(input map_t s, input logic [8:0] b, input logic [7:0] fx);
		map_t r = s;
		if (b == OssOff) begin
			r.hi_en = 1'b0;
		end else begin
			r.p2 = b[7:0];
			r.p3 = fx;
			r.hi_en = 1'b1;
		end
		r.bank = b;
		return r;
	endfunction

	function automatic map_t a0bf(input map_t s, input logic [7:0] b, input logic [7:0] n);
		map_t r = s;
		if ((b & n) != 8'd0) r.hi_en = 1'b0;
		else r = hi8(r, b & (n - 8'd1));
		r.bank = {1'b0, b};
		return r;
	endfunction

	// start mapping of a kind
	always_comb begin
		st = '0;
		case (kind_new)
			K_STD_8, K_PHOENIX_8, K_WILL_64, K_EXP_64, K_DIAMOND_64, K_SDX_64,
			K_WILL_32, K_SDX_128, K_ATRAX_128, K_ATMAX_128: st = hi8(st, 8'd0);
			K_STD_16, K_BLIZZARD_16: st = m16(st, 8'd0);
			K_OSS_16: begin
				st.p3 = 8'd3;
				st.hi_en = 1'b1;
			end
			K_DB_32, K_XEGS_32, K_SWXEGS_32: st = xegs(st, 8'd0, 8'h03);
			K_XEGS_64, K_SWXEGS_64: st = xegs(st, 8'd0, 8'h07);
			K_XEGS_128, K_SWXEGS_128: st = xegs(st, 8'd0, 8'h0f);
			K_XEGS_256, K_SWXEGS_256: st = xegs(st, 8'd0, 8'h1f);
			K_XEGS_512, K_SWXEGS_512: st = xegs(st, 8'd0, 8'h3f);
			K_XEGS_1024, K_SWXEGS_1024: st = xegs(st, 8'd0, 8'h7f);
			K_OSS2_16: begin
				st.p2 = 8'd1;
				st.hi_en = 1'b1;
			end
			K_BBSB_40: begin
				st.p1 = 8'd4;
				st.lo_en = 1'b1;
				st = hi8(st, 8'd4);
			end
			K_RIGHT_8: begin
				if (older) begin
					st = lo8(st, 8'd0);
					if (basic_wanted) begin
						st.hi_en = 1'b1;
						st.basic = 1'b1;
					end
				end
			end
			K_ATMAX_1024: begin
				st = hi8(st, 8'h7f);
				st.bank = 9'h07f;
			end
			default: begin
				if (kind_new >= K_MEGA_16 && kind_new <= K_MEGA_1024) begin
					st = m16(st, 8'd0);
				end else if (older && basic_wanted) begin
					st.hi_en = 1'b1;
					st.basic = 1'b1;
				end
			end
		endcase
	end

	// access rule
	always_comb begin
		logic [7:0] a, v, mm;
		logic [8:0] b;
		logic [3:0] t;
		a = op.addr;
		v = op.data;
		b = m_q.bank;
		nx = m_q;
		mm = 8'd0;
		t = 4'd0;
		if (op.is_write && kind >= K_MEGA_16 && kind <= K_MEGA_1024) begin
			mm = 8'h80 | ((8'd1 << (kind - K_MEGA_16)) - 8'd1);
			mm = v & mm;
			if (mm[7]) begin
				nx.lo_en = 1'b0;
				nx.hi_en = 1'b0;
			end else begin
				nx = m16(nx, {1'b0, mm[6:0]});
			end
			nx.bank = {1'b0, mm};
		end else if (op.is_write && kind == K_XEGS_32) nx = xegs(nx, v & 8'h03, 8'h03);
		else if (op.is_write && kind == K_XEGS_64) nx = xegs(nx, v & 8'h07, 8'h07);
		else if (op.is_write && kind == K_XEGS_128) nx = xegs(nx, v & 8'h0f, 8'h0f);
		else if (op.is_write && kind == K_XEGS_256) nx = xegs(nx, v & 8'h1f, 8'h1f);
		else if (op.is_write && kind == K_XEGS_512) nx = xegs(nx, v & 8'h3f, 8'h3f);
		else if (op.is_write && kind == K_XEGS_1024) nx = xegs(nx, v & 8'h7f, 8'h7f);
		else if (op.is_write && kind == K_ATRAX_128) nx = a0bf(nx, v & 8'h8f, 8'h80);
		else if (op.is_write && kind == K_SWXEGS_32) nx = xegs(nx, v & 8'h83, 8'h03);
		else if (op.is_write && kind == K_SWXEGS_64) nx = xegs(nx, v & 8'h87, 8'h07);
		else if (op.is_write && kind == K_SWXEGS_128) nx = xegs(nx, v & 8'h8f, 8'h0f);
		else if (op.is_write && kind == K_SWXEGS_256) nx = xegs(nx, v & 8'h9f, 8'h1f);
		else if (op.is_write && kind == K_SWXEGS_512) nx = xegs(nx, v & 8'hbf, 8'h3f);
		else if (op.is_write && kind == K_SWXEGS_1024) nx = xegs(nx, v, 8'h7f);
		else begin
			case (kind)
				K_OSS_16: begin
					if (a[3]) b = OssOff;
					else begin
						case (a[2:0])
							3'd0, 3'd1: b = 9'd0;
							3'd3, 3'd7: b = 9'd1;
							3'd4, 3'd5: b = 9'd2;
							default: b = b;
						endcase
					end
					nx = oss(nx, b, 8'd3);
				end
				K_DB_32: nx = xegs(nx, a & 8'h03, 8'h03);
				K_WILL_64: nx = a0bf(nx, a, 8'h08);
				K_WILL_32: nx = a0bf(nx, a & 8'h0b, 8'h08);
				K_EXP_64: if (a[7:4] == 4'h7) nx = a0bf(nx, a ^ 8'h07, 8'h08);
				K_DIAMOND_64: if (a[7:4] == 4'hd) nx = a0bf(nx, a ^ 8'h07, 8'h08);
				K_SDX_64: if (a[7:4] == 4'he) nx = a0bf(nx, a ^ 8'h07, 8'h08);
				K_SDX_128: begin
					if (a[7:5] == 3'b111) begin
						if (a[3]) nx.hi_en = 1'b0;
						else begin
							t = ({1'b0, a[2:0]} + {a[4], 3'd0}) ^ 4'hf;
							nx = hi8(nx, {4'd0, t});
						end
						nx.bank = {1'b0, a};
					end
				end
				K_OSS2_16: begin
					case ({a[3], a[0]})
						2'b00: b = 9'd1;
						2'b01: b = 9'd3;
						2'b10: b = OssOff;
						default: b = 9'd2;
					endcase
					nx = oss(nx, b, 8'd0);
				end
				K_PHOENIX_8: nx.hi_en = 1'b0;
				K_BLIZZARD_16: begin
					nx.lo_en = 1'b0;
					nx.hi_en = 1'b0;
				end
				K_ATMAX_128: if (a[7:5] == 3'd0) nx = a0bf(nx, a, 8'h10);
				K_ATMAX_1024: nx = a0bf(nx, a, 8'h80);
				default: nx = m_q;
			endcase
		end
	end

	assign op_ready = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (kind_wr) m_q <= st;
			else if (op_valid && op_ready) m_q <= nx;
			if (op_ready) out_valid_q <= op_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (op_valid && op_ready) begin
			out_q.read_value <= op.is_write ? 8'd0 : 8'hff;
			out_q.low_window_on <= nx.lo_en;
			out_q.high_window_on <= nx.hi_en;
			out_q.high_from_basic <= nx.basic;
			out_q.page_at_8000 <= pg({1'b0, nx.p0});
			out_q.page_at_9000 <= pg({1'b0, nx.p1});
			out_q.page_at_a000 <= pg({1'b0, nx.p2});
			out_q.page_at_b000 <= pg({1'b0, nx.p3});
		end
	end
endmodule

@@ hw/rtl/cartridge_bank_mapper.sv @@
// Top level of the cartridge bank mapper: config registers, front queue, back.
// Depends on cbm_pkg, cbm_front, cbm_back.
//
//  channel | signals                               | accepted when
//  in      | in_valid, in_ready, in_data           | in_valid && in_ready
//  out     | out_valid, out_ready, out_data        | out_valid && out_ready
//  config  | psel penable pwrite paddr pwdata      | psel&penable&pwrite
//
// One item per cycle sustained while the receiver takes results; an item
// enters the queue when accepted and is then decoded into the output
// register, where its result is shown until the receiver takes it.
// Reset zeroes the mapping and config registers: the empty-slot mapping.
// A full output register stalls the back; the two-entry queue keeps the
// front accepting meanwhile, until it fills.
module cartridge_bank_mapper import cbm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [5:0] kind_q;
	logic       older_q, basic_q;
	logic       wr, kind_wr;
	logic       op_valid, op_ready;
	op_t        op;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign kind_wr = wr && paddr[3:2] == RegKind && paddr[1:0] == 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= 6'd0;
			older_q <= 1'b0;
			basic_q <= 1'b0;
		end else if (wr && paddr[1:0] == 2'd0) begin
			case (paddr[3:2])
				RegKind: kind_q <= pwdata[5:0];
				RegOlder: older_q <= pwdata[0];
				RegBasic: basic_q <= pwdata[0];
				default: kind_q <= kind_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			RegKind: prdata = {26'd0, kind_q};
			RegOlder: prdata = {31'd0, older_q};
			RegBasic: prdata = {31'd0, basic_q};
			default: prdata = 32'd0;
		endcase
	end

	cbm_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.op_valid, .op_ready, .op
	);

	cbm_back u_back (
		.clk, .arst_n, .op_valid, .op_ready, .op,
		.kind_wr, .kind(kind_q), .kind_new(pwdata[5:0]),
		.older(older_q), .basic_wanted(basic_q),
		.out_valid, .out_ready, .out_data
	);
endmodule

@@ hw/rtl/cbm_checker.sv @@
// Port checker for the cartridge bank mapper, bound to the top level.
// Depends on cbm_pkg.
module cbm_port_props import cbm_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data,
	input logic      pready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out held");
	a_rv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.read_value == 8'd0 || out_data.read_value == 8'hff)
		else $error("read value");
	a_basic: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.high_from_basic |-> out_data.high_window_on)
		else $error("basic without window");
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready) else $error("pready");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_valid, in_ready, out_valid}))
		else $error("handshake unknown");
endmodule

bind cartridge_bank_mapper cbm_port_props u_chk (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data, .pready
);

@@ test/cbm_checker.sv @@
`timescale 1ns / 1ps
// Checker for the cartridge bank mapper: watches the item channels and the
// config port, predicts each result and compares it. Depends on cbm_pkg.
module cbm_checker import cbm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  in_item_t    in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  out_item_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output int          mismatches,
	output int          pending
);

	localparam logic [3:0] AddrKind  = 4'(RegKind) << 2;
	localparam logic [3:0] AddrOlder = 4'(RegOlder) << 2;
	localparam logic [3:0] AddrBasic = 4'(RegBasic) << 2;

	logic [5:0] kind;
	logic       older, basic_req;
	logic [8:0] bank;
	logic [7:0] wp [4];
	logic       lo_on, hi_on, basic_on;

	out_item_t expected_maps [$];

	task automatic low_pair(input int unsigned k);
		wp[0] = 8'(2 * k);
		wp[1] = 8'(2 * k + 1);
		lo_on = 1'b1;
	endtask

	task automatic high_pair(input int unsigned k);
		wp[2] = 8'(2 * k);
		wp[3] = 8'(2 * k + 1);
		hi_on = 1'b1;
	endtask

	task automatic quad(input int unsigned k);
		for (int i = 0; i < 4; i++)
			wp[i] = 8'(4 * k + i);
		lo_on = 1'b1;
		hi_on = 1'b1;
	endtask

	// 8K bank at 8000, fixed last bank at A000; bit 7 drops both windows
	task automatic xegs_bank(input int unsigned b, input int unsigned last);
		if (b & 'h80) begin
			lo_on = 1'b0;
			hi_on = 1'b0;
		end else begin
			low_pair(b & 'h7f);
			high_pair(last);
		end
		bank = 9'(b & 'hff);
	endtask

	task automatic oss_bank(input int unsigned b, input int unsigned fixed);
		if (b == OssOff) begin
			hi_on = 1'b0;
		end else begin
			wp[2] = 8'(b);
			wp[3] = 8'(fixed);
			hi_on = 1'b1;
		end
		bank = 9'(b);
	endtask

	task automatic right_bank(input int unsigned b, input int unsigned n);
		if (b & n)
			hi_on = 1'b0;
		else
			high_pair(b & (n - 1));
		bank = 9'(b & 'hff);
	endtask

	task automatic mega_bank(input int unsigned b);
		if (b & 'h80) begin
			lo_on = 1'b0;
			hi_on = 1'b0;
		end else begin
			quad(b & 'h7f);
		end
		bank = 9'(b & 'hff);
	endtask

	task automatic start_map();
		for (int i = 0; i < 4; i++)
			wp[i] = '0;
		lo_on = 1'b0;
		hi_on = 1'b0;
		basic_on = 1'b0;
		bank = '0;
		case (kind)
			K_STD_8, K_PHOENIX_8: high_pair(0);
			K_STD_16, K_BLIZZARD_16: quad(0);
			K_OSS_16: begin
				wp[2] = 8'd0; wp[3] = 8'd3; hi_on = 1'b1;
			end
			K_DB_32, K_XEGS_32, K_SWXEGS_32: xegs_bank(0, 'h03);
			K_XEGS_64, K_SWXEGS_64: xegs_bank(0, 'h07);
			K_XEGS_128, K_SWXEGS_128: xegs_bank(0, 'h0f);
			K_XEGS_256, K_SWXEGS_256: xegs_bank(0, 'h1f);
			K_XEGS_512, K_SWXEGS_512: xegs_bank(0, 'h3f);
			K_XEGS_1024, K_SWXEGS_1024: xegs_bank(0, 'h7f);
			K_WILL_64, K_EXP_64, K_DIAMOND_64, K_SDX_64, K_WILL_32, K_SDX_128,
			K_ATRAX_128, K_ATMAX_128: high_pair(0);
			K_OSS2_16: begin
				wp[2] = 8'd1; wp[3] = 8'd0; hi_on = 1'b1;
			end
			K_BBSB_40: begin
				wp[0] = 8'd0; wp[1] = 8'd4; lo_on = 1'b1;
				high_pair(4);
			end
			K_RIGHT_8: begin
				if (older) begin
					low_pair(0);
					if (basic_req) begin
						hi_on = 1'b1;
						basic_on = 1'b1;
					end
				end
			end
			K_ATMAX_1024: begin
				high_pair('h7f);
				bank = 9'h7f;
			end
			default: begin
				if (kind >= K_MEGA_16 && kind <= K_MEGA_1024) begin
					quad(0);
				end else if (older && basic_req) begin
					hi_on = 1'b1;
					basic_on = 1'b1;
				end
			end
		endcase
	endtask

	// address-decoded banking, shared by reads and by writes of most kinds
	task automatic addr_access(input int unsigned a);
		int unsigned b;
		b = bank;
		case (kind)
			K_OSS_16: begin
				if (a & 'h08)
					b = OssOff;
				else
					case (a & 7)
						0, 1: b = 0;
						3, 7: b = 1;
						4, 5: b = 2;
						default: ;
					endcase
				oss_bank(b, 3);
			end
			K_DB_32: xegs_bank(a & 3, 3);
			K_WILL_64: right_bank(a, 8);
			K_WILL_32: right_bank(a & 'h0b, 8);
			K_EXP_64: if ((a & 'hf0) == 'h70) right_bank(a ^ 7, 8);
			K_DIAMOND_64: if ((a & 'hf0) == 'hd0) right_bank(a ^ 7, 8);
			K_SDX_64: if ((a & 'hf0) == 'he0) right_bank(a ^ 7, 8);
			K_SDX_128: begin
				if ((a & 'he0) == 'he0) begin
					if (a & 'h08)
						hi_on = 1'b0;
					else
						high_pair((((a & 7) + ((a & 'h10) >> 1)) ^ 'h0f) & 'h0f);
					bank = 9'(a);
				end
			end
			K_OSS2_16: begin
				case (a & 'h09)
					'h00: b = 1;
					'h01: b = 3;
					'h08: b = OssOff;
					default: b = 2;
				endcase
				oss_bank(b, 0);
			end
			K_PHOENIX_8: hi_on = 1'b0;
			K_BLIZZARD_16: begin
				lo_on = 1'b0;
				hi_on = 1'b0;
			end
			K_ATMAX_128: if ((a & 'he0) == 0) right_bank(a, 16);
			K_ATMAX_1024: right_bank(a, 128);
			default: ;
		endcase
	endtask

	task automatic data_access(input int unsigned a, input int unsigned v);
		case (kind)
			K_XEGS_32: xegs_bank(v & 'h03, 'h03);
			K_XEGS_64: xegs_bank(v & 'h07, 'h07);
			K_XEGS_128: xegs_bank(v & 'h0f, 'h0f);
			K_XEGS_256: xegs_bank(v & 'h1f, 'h1f);
			K_XEGS_512: xegs_bank(v & 'h3f, 'h3f);
			K_XEGS_1024: xegs_bank(v & 'h7f, 'h7f);
			K_ATRAX_128: right_bank(v & 'h8f, 128);
			K_SWXEGS_32: xegs_bank(v & 'h83, 'h03);
			K_SWXEGS_64: xegs_bank(v & 'h87, 'h07);
			K_SWXEGS_128: xegs_bank(v & 'h8f, 'h0f);
			K_SWXEGS_256: xegs_bank(v & 'h9f, 'h1f);
			K_SWXEGS_512: xegs_bank(v & 'hbf, 'h3f);
			K_SWXEGS_1024: xegs_bank(v & 'hff, 'h7f);
			default: begin
				if (kind >= K_MEGA_16 && kind <= K_MEGA_1024)
					mega_bank(v & ('h80 | ((1 << (kind - K_MEGA_16)) - 1)));
				else
					addr_access(a);
			end
		endcase
	endtask

	function automatic out_item_t mapping_now(input logic is_write);
		out_item_t r;
		r.read_value = is_write ? 8'h00 : 8'hff;
		r.low_window_on = lo_on;
		r.high_window_on = hi_on;
		r.high_from_basic = basic_on;
		r.page_at_8000 = PageW'(wp[0] % ImagePages);
		r.page_at_9000 = PageW'(wp[1] % ImagePages);
		r.page_at_a000 = PageW'(wp[2] % ImagePages);
		r.page_at_b000 = PageW'(wp[3] % ImagePages);
		return r;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	assign pending = expected_maps.size();

	always @(posedge clk or negedge arst_n) begin
		out_item_t w;
		if (!arst_n) begin
			kind = '0;
			older = 1'b0;
			basic_req = 1'b0;
			start_map();
			expected_maps.delete();
			mismatches = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					AddrKind: begin
						kind = pwdata[5:0];
						start_map();
					end
					AddrOlder: older = pwdata[0];
					AddrBasic: basic_req = pwdata[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (in_data.req_type)
					data_access(in_data.page_offset, in_data.write_value);
				else
					addr_access(in_data.page_offset);
				expected_maps.push_back(mapping_now(in_data.req_type));
			end
			if (out_valid && out_ready) begin
				if (expected_maps.size() == 0) begin
					report("unexpected item", 0, 0);
				end else begin
					w = expected_maps.pop_front();
					if (out_data.read_value !== w.read_value)
						report("read_value", out_data.read_value, w.read_value);
					if (out_data.low_window_on !== w.low_window_on)
						report("low_window_on", out_data.low_window_on, w.low_window_on);
					if (out_data.high_window_on !== w.high_window_on)
						report("high_window_on", out_data.high_window_on, w.high_window_on);
					if (out_data.high_from_basic !== w.high_from_basic)
						report("high_from_basic", out_data.high_from_basic,
							w.high_from_basic);
					if (out_data.page_at_8000 !== w.page_at_8000)
						report("page_at_8000", out_data.page_at_8000, w.page_at_8000);
					if (out_data.page_at_9000 !== w.page_at_9000)
						report("page_at_9000", out_data.page_at_9000, w.page_at_9000);
					if (out_data.page_at_a000 !== w.page_at_a000)
						report("page_at_a000", out_data.page_at_a000, w.page_at_a000);
					if (out_data.page_at_b000 !== w.page_at_b000)
						report("page_at_b000", out_data.page_at_b000, w.page_at_b000);
				end
			end
		end
	end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Top of the cartridge bank mapper testbench: clock, reset, stimulus, verdict.
// Depends on cbm_pkg, cartridge_bank_mapper and cbm_checker.
module tb;
	import cbm_pkg::*;

	localparam int StallLimit = 1000;  // cycles with no handshake at all
	localparam int DrainCycles = 6;    // pipeline is two deep; a little margin

	logic        clk;
	logic        arst_n;
	logic        in_valid, in_ready;
	in_item_t    in_data;
	logic        out_valid, out_ready;
	out_item_t   out_data;
	logic        psel, penable, pwrite, pready;
	logic [3:0]  paddr;
	logic [31:0] pwdata, prdata;
	int          mismatches, pending;
	int          quiet_cycles;
	bit          steady;  // no idling on either side while set

	cartridge_bank_mapper dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	cbm_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.mismatches(mismatches), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: stalls ~37% of cycles except in the steady stretch
	always @(posedge clk or negedge arst_n)
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= steady || ($urandom_range(99) >= 37);

	// watchdog: any handshake on any channel resets the count
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// one item; idles first at random, drops valid only when a gap follows
	task automatic send_item(input in_item_t it);
		int gap;
		gap = 0;
		if (!steady)
			while ($urandom_range(99) < 37)
				gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_access(input bit w, input int a, input int v);
		in_item_t it;
		it.req_type = w;
		it.page_offset = 8'(a);
		it.write_value = 8'(v);
		send_item(it);
	endtask

	// offsets biased toward the decode windows the banked kinds look at
	function automatic in_item_t random_access();
		in_item_t it;
		it.req_type = 1'($urandom_range(1));
		it.write_value = 8'($urandom_range(255));
		case ($urandom_range(5))
			0: it.page_offset = 8'h70 | 8'($urandom_range(15));
			1: it.page_offset = 8'hd0 | 8'($urandom_range(15));
			2: it.page_offset = 8'he0 | 8'($urandom_range(31));
			3: it.page_offset = 8'($urandom_range(31));
			default: it.page_offset = 8'($urandom_range(255));
		endcase
		return it;
	endfunction

	// only when idle: drain results, let the pipe empty, then two-phase write
	task automatic write_reg(input logic [1:0] idx, input int unsigned val);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 4'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_cart(input int unsigned k, input bit old, input bit bas);
		write_reg(RegOlder, old ? 32'h1 : 32'hffff_fffe);
		write_reg(RegBasic, bas ? 32'hffff_ffff : 32'h0);
		write_reg(RegKind, k);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		steady = 1'b0;
		quiet_cycles = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty slot right after reset, OSS decode of each offset, then SWXEGS 1024 bank writes
		send_access(1'b0, 8'h00, 8'h00);
		send_access(1'b1, 8'hff, 8'hff);
		set_cart(K_OSS_16, 1'b1, 1'b1);
		for (int a = 0; a < 16; a++)
			send_access(a[0], a, 8'hff);
		send_access(1'b0, 8'hff, 8'h00);
		set_cart(K_SWXEGS_1024, 1'b0, 1'b0);
		send_access(1'b1, 8'h00, 8'h7f);
		send_access(1'b1, 8'h00, 8'h80);
		send_access(1'b1, 8'h00, 8'hff);
		send_access(1'b0, 8'hff, 8'hff);

		// random: every kind value, then the basic-fallback combinations again
		for (int ph = 0; ph < 72; ph++) begin
			int unsigned k;
			bit old, bas;
			k = (ph < 64) ? ph : ((ph & 1) ? K_RIGHT_8 : 0);
			old = (ph < 64) ? 1'($urandom_range(1)) : ph[1];
			bas = (ph < 64) ? 1'($urandom_range(1)) : ph[2];
			set_cart(k, old, bas);
			steady = (ph >= 30 && ph < 38);
			repeat (15) send_item(random_access());
		end
		in_valid <= 1'b0;
		steady = 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
